/* rtl/reliable_datagram_frame_receiver_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the reliable datagram frame receiver
// Same-cycle and next-cycle implication checks on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef RELIABLE_DATAGRAM_FRAME_RECEIVER_ASSERT_SVH
`define RELIABLE_DATAGRAM_FRAME_RECEIVER_ASSERT_SVH

// Check that post holds in the cycle in which pre holds.
`define RDFR_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check that post holds in the cycle after pre holds.
`define RDFR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/rdfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfr_pkg
// Types and constants shared by the datagram frame receiver modules.
// ----------------------------------------------------------------------------
package rdfr_pkg;

  localparam int PREAMBLE_LEN = 8;
  localparam int POS_W        = 4;
  localparam int CFG_AW       = 2;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = 2;

  localparam logic [7:0] PREAMBLE_EVEN = 8'hAA;
  localparam logic [7:0] PREAMBLE_ODD  = 8'h55;
  localparam logic [7:0] ID_WRAP       = 8'hFF;

  localparam logic [POS_W-1:0] POS_CLASS = POS_W'(PREAMBLE_LEN);
  localparam logic [POS_W-1:0] POS_SUB   = POS_W'(PREAMBLE_LEN + 1);
  localparam logic [POS_W-1:0] POS_LEN0  = POS_W'(PREAMBLE_LEN + 2);
  localparam logic [POS_W-1:0] POS_LEN1  = POS_W'(PREAMBLE_LEN + 3);
  localparam logic [POS_W-1:0] POS_BODY  = POS_W'(PREAMBLE_LEN + 4);

  typedef enum logic [CFG_AW-1:0] {
    CFG_UNRELIABLE_CODE = 2'd0,
    CFG_RELIABLE_CODE   = 2'd1,
    CFG_NORMAL_CODE     = 2'd2,
    CFG_ACK_CODE        = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FC_PENDING  = 2'd0,
    FC_NORMAL   = 2'd1,
    FC_ACK      = 2'd2,
    FC_RELIABLE = 2'd3
  } fc_t;

  typedef enum logic [1:0] {
    K_UNREL_DATA = 2'd0,
    K_REL_DATA   = 2'd1,
    K_ACK_RX     = 2'd2,
    K_SEND_ACK   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       message_end;
    logic       truncated;
  } res_t;

  typedef struct packed {
    logic two;
    res_t r0;
    res_t r1;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/rdfr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfr_front
// Parse datagram bytes, track frame state and build result entries.
// ----------------------------------------------------------------------------
module rdfr_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rdfr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [7:0]                  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tlast,
  input  rdfr_pkg::fifo_stat_t        fifo_st,
  output logic                        push,
  output rdfr_pkg::entry_t            push_entry
);
  import rdfr_pkg::*;

  logic [7:0]       unrel_code_r, rel_code_r, normal_code_r, ack_code_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             dropped_r, dropped_nxt;
  fc_t              class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic             accepted_r, accepted_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [15:0]      cnt_r, cnt_nxt;
  logic [7:0]       last_id_r, last_id_nxt;

  logic        take;
  logic [7:0]  b;
  logic [7:0]  want;
  logic [15:0] cnt_inc;
  logic        last_byte;
  logic        deliver;
  logic        emitted;
  logic        has0, has1;
  res_t        res0, res1;
  kind_t       data_kind;

  assign in_tready = !fifo_st.full;
  assign take      = in_tvalid && in_tready;
  assign b         = in_tdata;
  assign want      = pos_r[0] ? PREAMBLE_ODD : PREAMBLE_EVEN;
  assign cnt_inc   = cnt_r + 16'd1;
  assign last_byte = (cnt_inc == len_r);

  always_comb begin
    pos_nxt      = pos_r;
    dropped_nxt  = dropped_r;
    class_nxt    = class_r;
    id_nxt       = id_r;
    accepted_nxt = accepted_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    last_id_nxt  = last_id_r;
    emitted      = 1'b0;
    has0         = 1'b0;
    has1         = 1'b0;
    deliver      = 1'b0;
    data_kind    = (class_r == FC_RELIABLE) ? K_REL_DATA : K_UNREL_DATA;
    res0         = '{kind: K_ACK_RX, value: b, message_end: 1'b1, truncated: 1'b0};
    res1         = '{kind: K_SEND_ACK, value: 8'd0, message_end: 1'b1, truncated: 1'b0};

    if (!dropped_r) begin
      priority if (pos_r < POS_CLASS) begin
        if (b != want) begin
          dropped_nxt = 1'b1;
        end
      end else if (pos_r == POS_CLASS) begin
        priority if (b == unrel_code_r) begin
          class_nxt = FC_PENDING;
        end else if (b == rel_code_r) begin
          class_nxt = FC_RELIABLE;
        end else begin
          dropped_nxt = 1'b1;
        end
      end else if (pos_r == POS_SUB) begin
        priority if (class_r == FC_RELIABLE) begin
          id_nxt = b;
          if ((b == 8'd0 && last_id_r == ID_WRAP) || b > last_id_r) begin
            accepted_nxt = 1'b1;
            last_id_nxt  = b;
          end
        end else if (b == normal_code_r) begin
          class_nxt = FC_NORMAL;
        end else if (b == ack_code_r) begin
          class_nxt = FC_ACK;
        end else begin
          dropped_nxt = 1'b1;
        end
      end else if (pos_r == POS_LEN0) begin
        if (class_r == FC_ACK) begin
          has0 = 1'b1;
        end else begin
          len_nxt = {8'd0, b};
        end
      end else if (pos_r == POS_LEN1) begin
        if (class_r != FC_ACK) begin
          len_nxt = {b, len_r[7:0]};
        end
      end else begin
        deliver = (class_r == FC_NORMAL) || (class_r == FC_RELIABLE && accepted_r);
        if (deliver && cnt_r < len_r) begin
          cnt_nxt = cnt_inc;
          has0    = 1'b1;
          emitted = 1'b1;
          res0    = '{kind: data_kind, value: b,
                      message_end: last_byte || in_tlast,
                      truncated: in_tlast && !last_byte};
        end
      end
    end

    if (pos_r < POS_BODY) begin
      pos_nxt = pos_r + POS_W'(1);
    end

    if (in_tlast) begin
      if (!dropped_nxt && pos_r >= POS_SUB) begin
        deliver = (class_nxt == FC_NORMAL) || (class_nxt == FC_RELIABLE && accepted_nxt);
        if (deliver && !emitted && (pos_r < POS_LEN1 || cnt_nxt < len_nxt)) begin
          has0 = 1'b1;
          res0 = '{kind: (class_nxt == FC_RELIABLE) ? K_REL_DATA : K_UNREL_DATA,
                   value: 8'd0, message_end: 1'b1, truncated: 1'b1};
        end
        if (class_nxt == FC_RELIABLE) begin
          has1       = 1'b1;
          res1.value = id_nxt;
        end
      end
      pos_nxt      = '0;
      dropped_nxt  = 1'b0;
      class_nxt    = FC_PENDING;
      id_nxt       = 8'd0;
      accepted_nxt = 1'b0;
      len_nxt      = 16'd0;
      cnt_nxt      = 16'd0;
    end
  end

  assign push           = take && (has0 || has1);
  assign push_entry.two = has0 && has1;
  assign push_entry.r0  = has0 ? res0 : res1;
  assign push_entry.r1  = res1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unrel_code_r  <= 8'd0;
      rel_code_r    <= 8'd1;
      normal_code_r <= 8'd0;
      ack_code_r    <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_UNRELIABLE_CODE: unrel_code_r  <= cfg_wdata;
        CFG_RELIABLE_CODE:   rel_code_r    <= cfg_wdata;
        CFG_NORMAL_CODE:     normal_code_r <= cfg_wdata;
        CFG_ACK_CODE:        ack_code_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      dropped_r  <= 1'b0;
      class_r    <= FC_PENDING;
      id_r       <= 8'd0;
      accepted_r <= 1'b0;
      len_r      <= 16'd0;
      cnt_r      <= 16'd0;
      last_id_r  <= ID_WRAP;
    end else if (take) begin
      pos_r      <= pos_nxt;
      dropped_r  <= dropped_nxt;
      class_r    <= class_nxt;
      id_r       <= id_nxt;
      accepted_r <= accepted_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      last_id_r  <= last_id_nxt;
    end
  end

endmodule

/* rtl/rdfr_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfr_fifo
// Short register queue of result entries between front and back.
// ----------------------------------------------------------------------------
module rdfr_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rdfr_pkg::entry_t     push_entry,
  input  logic                 pop,
  output rdfr_pkg::entry_t     head,
  output rdfr_pkg::fifo_stat_t stat
);
  import rdfr_pkg::*;

  entry_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + (FIFO_AW + 1)'(1);
      2'b01:   cnt_nxt = cnt_r - (FIFO_AW + 1)'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/rdfr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfr_back
// Drain queued entries into the output register: one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module rdfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rdfr_pkg::entry_t     head,
  input  rdfr_pkg::fifo_stat_t fifo_st,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] value
  output logic                 out_tlast,
  output logic [3:0]           out_tuser   // [1:0] kind, [2] truncated, [3] last_result
);
  import rdfr_pkg::*;

  logic out_valid_r;
  logic phase_r;
  res_t out_res_r;
  logic out_lastres_r;
  logic load;
  logic avail;

  assign load  = !out_valid_r || out_tready;
  assign avail = load && !fifo_st.empty;
  assign pop   = avail && (!head.two || phase_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else if (load) begin
      out_valid_r <= !fifo_st.empty;
      if (avail) begin
        phase_r <= head.two && !phase_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (avail) begin
      out_res_r     <= phase_r ? head.r1 : head.r0;
      out_lastres_r <= !head.two || phase_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tlast  = out_res_r.message_end;
  assign out_tuser  = {out_lastres_r, out_res_r.truncated, out_res_r.kind};

endmodule

/* rtl/reliable_datagram_frame_receiver.sv */
`timescale 1ns / 1ps
// Each result passes through the result queue and then the output register to out_*.
// Throughput: one byte per cycle while the queue has room; one result per cycle
// leaves the output register while out_tready allows. A datagram end with a payload or
// marker and a send-ack request yields two results in turn; a four-entry queue buffers them.
// Reset: synchronous active-low rst_n clears frame state, restores register
// defaults and sets the last accepted id to 255; no clearing pass.
`include "reliable_datagram_frame_receiver_assert.svh"
// ----------------------------------------------------------------------------
// reliable_datagram_frame_receiver
// Checks preamble, classifies datagrams, filters reliable ids, emits results.
// ----------------------------------------------------------------------------
module reliable_datagram_frame_receiver (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rdfr_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [7:0]                  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,   // [7:0] data_byte
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,  // [7:0] value
  output logic                        out_tlast,
  output logic [3:0]                  out_tuser   // [1:0] kind, [2] truncated, [3] last_result
);
  import rdfr_pkg::*;

  fifo_stat_t fifo_st;
  entry_t     push_entry;
  entry_t     head;
  logic       push;
  logic       pop;

  rdfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .fifo_st    (fifo_st),
    .push       (push),
    .push_entry (push_entry)
  );

  rdfr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_st)
  );

  rdfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .fifo_st    (fifo_st),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `RDFR_ASSERT_NOW(a_no_overflow, fifo_st.full, !push, "queue push while full")
  `RDFR_ASSERT_NOW(a_no_underflow, pop, !fifo_st.empty, "queue pop while empty")
  `RDFR_ASSERT_NOW(a_ack_flags, out_tvalid && out_tuser[1:0] == K_SEND_ACK,
                   out_tlast && !out_tuser[2] && out_tuser[3], "bad send-ack flags")
  `RDFR_ASSERT_NEXT(a_pair_follows, out_tvalid && out_tready && !out_tuser[3],
                    out_tvalid && out_tuser[1:0] == K_SEND_ACK, "missing send-ack")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: reliable datagram frame receiver testbench
// Streams preamble-framed datagrams (normal data, acks, reliable data with
// fresh, repeated and wrapped ids, broken and cut-short frames, line noise)
// through the receiver under random source and sink stalls. A scoreboard
// predicts every result from the bytes it sees accepted and compares each
// result taken from the output, field by field. The class and subtype codes
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import rdfr_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 260;
  localparam int MAX_BODY    = 40;
  localparam int NUM_PHASES  = 5;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       message_end;
    logic       truncated;
    logic       last_result;
  } frame_result_t;

  class datagram_tracker;
    logic [7:0]    unrel_code, rel_code, normal_code, ack_code;
    logic [3:0]    byte_pos;
    logic          dropped;
    fc_t           fclass;
    logic [7:0]    msg_id;
    logic          accepted;
    logic [15:0]   pay_len, pay_cnt;
    logic [7:0]    last_id;
    frame_result_t expected_results[$];
    int            fails;

    function new();
      unrel_code  = 8'd0;
      rel_code    = 8'd1;
      normal_code = 8'd0;
      ack_code    = 8'd1;
      last_id     = ID_WRAP;
      fails       = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      byte_pos = '0;
      dropped  = 1'b0;
      fclass   = FC_PENDING;
      msg_id   = '0;
      accepted = 1'b0;
      pay_len  = '0;
      pay_cnt  = '0;
    endfunction

    function void set_code(cfg_idx_t idx, logic [7:0] v);
      case (idx)
        CFG_UNRELIABLE_CODE: unrel_code = v;
        CFG_RELIABLE_CODE:   rel_code = v;
        CFG_NORMAL_CODE:     normal_code = v;
        CFG_ACK_CODE:        ack_code = v;
        default: ;
      endcase
    endfunction

    function void add_result(kind_t k, logic [7:0] v, logic me, logic tr);
      expected_results.push_back('{k, v, me, tr, 1'b0});
    endfunction

    function kind_t data_kind();
      return (fclass == FC_RELIABLE) ? K_REL_DATA : K_UNREL_DATA;
    endfunction

    function logic delivering();
      return fclass == FC_NORMAL || (fclass == FC_RELIABLE && accepted);
    endfunction

    // advance the frame state by one accepted byte and queue its results
    function void take_byte(logic [7:0] b, logic fin);
      logic [3:0] pos;
      logic       emitted;
      logic       done;
      int         n0;
      pos     = byte_pos;
      emitted = 1'b0;
      n0      = expected_results.size();
      if (!dropped) begin
        if (pos < PREAMBLE_LEN) begin
          if (b != (pos[0] ? PREAMBLE_ODD : PREAMBLE_EVEN)) dropped = 1'b1;
        end else if (pos == POS_CLASS) begin
          if (b == unrel_code) fclass = FC_PENDING;
          else if (b == rel_code) fclass = FC_RELIABLE;
          else dropped = 1'b1;
        end else if (pos == POS_SUB) begin
          if (fclass == FC_RELIABLE) begin
            msg_id = b;
            if ((b == 8'd0 && last_id == ID_WRAP) || b > last_id) begin
              accepted = 1'b1;
              last_id  = b;
            end
          end else if (b == normal_code) begin
            fclass = FC_NORMAL;
          end else if (b == ack_code) begin
            fclass = FC_ACK;
          end else begin
            dropped = 1'b1;
          end
        end else if (pos == POS_LEN0) begin
          if (fclass == FC_ACK) add_result(K_ACK_RX, b, 1'b1, 1'b0);
          else pay_len = {8'd0, b};
        end else if (pos == POS_LEN1) begin
          if (fclass != FC_ACK) pay_len[15:8] = b;
        end else if (delivering() && pay_cnt < pay_len) begin
          pay_cnt = pay_cnt + 16'd1;
          done    = (pay_cnt == pay_len);
          add_result(data_kind(), b, done || fin, fin && !done);
          emitted = 1'b1;
        end
      end
      if (pos < POS_BODY) byte_pos = pos + 4'd1;
      if (fin) begin
        if (!dropped && pos >= POS_SUB) begin
          if (delivering() && !emitted && (pos < POS_LEN1 || pay_cnt < pay_len))
            add_result(data_kind(), 8'd0, 1'b1, 1'b1);
          if (fclass == FC_RELIABLE) add_result(K_SEND_ACK, msg_id, 1'b1, 1'b0);
        end
        clear_frame();
      end
      if (expected_results.size() > n0)
        expected_results[expected_results.size() - 1].last_result = 1'b1;
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        fails++;
      end
    endfunction

    function void match_result(frame_result_t got);
      frame_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got kind %0h value %0h",
                 $time, got.kind, got.value);
        fails++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", want.kind, got.kind);
      compare_field("value", want.value, got.value);
      compare_field("message_end", want.message_end, got.message_end);
      compare_field("truncated", want.truncated, got.truncated);
      compare_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_addr = CFG_UNRELIABLE_CODE;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [3:0] out_tuser;

  datagram_tracker sb;
  logic [7:0]      frame_buf[$];
  int              items_sent = 0;
  bit              sender_calm = 1'b0;
  int              hold_asked = 0;
  int              hold_done = 0;
  int              stall_left = 0;
  int              free_left = 0;
  int              sink_draw;
  int              idle_cycles = 0;

  reliable_datagram_frame_receiver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #5 clk = ~clk;

  // sink: check results, stall at random, hold off long on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready)
        sb.match_result('{kind_t'(out_tuser[1:0]), out_tdata, out_tlast,
                          out_tuser[2], out_tuser[3]});
      if (hold_asked != hold_done) begin
        hold_done  = hold_asked;
        stall_left = LONG_HOLD;
        free_left  = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (free_left > 0) begin
          free_left--;
        end else begin
          sink_draw = $urandom_range(0, 99);
          if (sink_draw < 3) free_left = 60;
          else if (sink_draw < 55) stall_left = 0;
          else if (sink_draw < 92) stall_left = $urandom_range(1, 3);
          else stall_left = $urandom_range(6, 30);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_tdata  <= b;
    in_tlast  <= fin;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.take_byte(b, fin);
    items_sent++;
  endtask

  task automatic gap_after(input int g);
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
      if (i != frame_buf.size() - 1) gap_after(draw_gap());
    end
  endtask

  task automatic load_preamble();
    frame_buf.delete();
    for (int i = 0; i < PREAMBLE_LEN; i++)
      frame_buf.push_back(i[0] ? PREAMBLE_ODD : PREAMBLE_EVEN);
  endtask

  task automatic send_datagram();
    int          r;
    int          body;
    logic [7:0]  cls;
    logic [7:0]  sub;
    logic [15:0] len;
    if ($urandom_range(0, 99) < 5) begin
      frame_buf.delete();
      repeat ($urandom_range(1, 20)) frame_buf.push_back(8'($urandom));
    end else begin
      load_preamble();
      if ($urandom_range(0, 99) < 8)
        frame_buf[$urandom_range(0, PREAMBLE_LEN - 1)] = 8'($urandom);
      r   = $urandom_range(0, 99);
      cls = (r < 40) ? sb.unrel_code : (r < 85) ? sb.rel_code : 8'($urandom);
      frame_buf.push_back(cls);
      r = $urandom_range(0, 99);
      if (cls == sb.rel_code && cls != sb.unrel_code) begin
        sub = (r < 50) ? sb.last_id + 8'd1 : (r < 65) ? sb.last_id :
              (r < 75) ? 8'd0 : 8'($urandom);
      end else begin
        sub = (r < 55) ? sb.normal_code : (r < 85) ? sb.ack_code : 8'($urandom);
      end
      frame_buf.push_back(sub);
      if (cls == sb.unrel_code && sub == sb.ack_code && sub != sb.normal_code) begin
        frame_buf.push_back(8'($urandom));
      end else begin
        r   = $urandom_range(0, 99);
        len = (r < 70) ? 16'($urandom_range(0, 6)) :
              (r < 90) ? 16'($urandom_range(7, MAX_BODY)) : 16'($urandom);
        body = (len > MAX_BODY) ? $urandom_range(0, MAX_BODY) : len;
        frame_buf.push_back(len[7:0]);
        frame_buf.push_back(len[15:8]);
        repeat (body) frame_buf.push_back(8'($urandom));
      end
      if ($urandom_range(0, 99) < 10)
        repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
      if ($urandom_range(0, 99) < 15) begin
        r = $urandom_range(1, frame_buf.size());
        while (frame_buf.size() > r) void'(frame_buf.pop_back());
      end
    end
    send_frame();
  endtask

  task automatic set_codes(input logic [7:0] u, input logic [7:0] r,
                           input logic [7:0] n, input logic [7:0] a);
    logic [7:0] v[4];
    v = '{u, r, n, a};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= cfg_idx_t'(i);
      cfg_wdata <= v[i];
      @(posedge clk);
      sb.set_code(cfg_idx_t'(i), v[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    int target;
    int frames;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reliable id 0 right after reset, one-byte payload
    load_preamble();
    frame_buf.push_back(sb.rel_code);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h01);
    frame_buf.push_back(8'h00);
    frame_buf.push_back(8'hff);
    send_frame();
    gap_after(draw_gap());
    // ack with a trailing byte
    load_preamble();
    frame_buf.push_back(sb.unrel_code);
    frame_buf.push_back(sb.ack_code);
    frame_buf.push_back(8'hff);
    frame_buf.push_back(8'h00);
    send_frame();
    gap_after(draw_gap());
    // one-byte datagram
    frame_buf.delete();
    frame_buf.push_back(8'h00);
    send_frame();
    gap_after(draw_gap());

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1: set_codes(8'hff, 8'h00, 8'hff, 8'h00);
        2: set_codes(8'h07, 8'h07, 8'h03, 8'h03);
        3: set_codes(8'haa, 8'h55, 8'h00, 8'hff);
        4: set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
      if (ph == 0) begin
        hold_asked++;
        sender_calm = 1'b1;
      end
      target = items_sent + PHASE_ITEMS;
      frames = 0;
      while (items_sent < target) begin
        if (ph != 0 || frames >= 8) sender_calm = ($urandom_range(0, 99) < 15);
        send_datagram();
        frames++;
        gap_after(draw_gap());
      end
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* reliable_datagram_frame_receiver.f */
+incdir+rtl
rtl/rdfr_pkg.sv
rtl/rdfr_front.sv
rtl/rdfr_fifo.sv
rtl/rdfr_back.sv
rtl/reliable_datagram_frame_receiver.sv
tb/tb.sv
